// File: sv/smds_pkg.sv
// shared constants, types and codes for the slot map block
package smds_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MINT_W     = CNT_W + 1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SPARE = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic rd;
    logic modify;
    logic fin;
    logic load;
  } cmd_t;

endpackage

// File: sv/smds_ram.sv
// generic single write port, single read port ram with registered read
module smds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/smds_ctrl.sv
// sequencing state machine and output handshake for the slot map
module smds_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output smds_pkg::cmd_t   cmd
);
  import smds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MOD  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   accept;
  logic   out_valid_next;

  assign out_free = !out_valid || !out_stall;
  // a new beat may enter while the finishing one is handed to the output register
  assign in_stall = !((state == S_IDLE) || ((state == S_FIN) && out_free));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.latch  = accept;
    cmd.rd     = (state == S_READ);
    cmd.modify = (state == S_MOD);
    cmd.fin    = (state == S_FIN);
    cmd.load   = (state == S_FIN) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_READ;
      end
      S_READ: state_next = S_MOD;
      S_MOD:  state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = accept ? S_READ : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: sv/smds_dp.sv
// datapath: packed store, both maps, counters and result register
module smds_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  smds_pkg::cmd_t                  cmd,
  input  smds_pkg::op_t                   op,
  input  logic [smds_pkg::IDX_W-1:0]      handle_in,
  input  logic [smds_pkg::DATA_WIDTH-1:0] value_in,
  output logic [smds_pkg::IDX_W-1:0]      handle_out,
  output logic [smds_pkg::DATA_WIDTH-1:0] value_out,
  output logic [smds_pkg::CNT_W-1:0]      live_count,
  output smds_pkg::status_t               status
);
  import smds_pkg::*;

  op_t                   op_q;
  logic [IDX_W-1:0]      h_q;
  logic [DATA_WIDTH-1:0] v_q;
  logic [CNT_W-1:0]      size, size_next;
  logic [CNT_W-1:0]      free_cnt, free_next;

  logic [CNT_W-1:0]      size_m1;
  logic [IDX_W-1:0]      size_idx, last;
  logic [MINT_W-1:0]     minted;
  logic                  h_bad;
  status_t               st_c;
  logic                  ok;
  logic [IDX_W-1:0]      nh;

  logic                  st_we, st_re;
  logic [IDX_W-1:0]      st_waddr, st_raddr;
  logic [DATA_WIDTH-1:0] st_wdata, st_rdata;
  logic                  hs_we;
  logic [IDX_W-1:0]      hs_waddr, hs_wdata, hs_rdata;
  logic                  sh_we;
  logic [IDX_W-1:0]      sh_waddr, sh_wdata, sh_raddr, sh_rdata;

  assign size_m1  = size - CNT_W'(1);
  assign size_idx = size[IDX_W-1:0];
  assign last     = size_m1[IDX_W-1:0];
  assign minted   = MINT_W'(size) + MINT_W'(free_cnt);
  assign h_bad    = MINT_W'(h_q) >= minted;

  always_comb begin
    case (op_q)
      OP_ADD:    st_c = (size == CNT_W'(CAPACITY)) ? ST_FULL : ST_OK;
      OP_REMOVE: st_c = (h_bad || size == '0) ? ST_RANGE : ST_OK;
      OP_GET:    st_c = h_bad ? ST_RANGE : ST_OK;
      default:   st_c = ST_OK;
    endcase
  end
  assign ok = (st_c == ST_OK);

  // recycled handle sits on the free stack just past the packed end
  assign nh = (free_cnt != '0) ? sh_rdata : size_idx;

  // packed store: remove reads the last word, get reads through the handle map
  always_comb begin
    st_re    = (cmd.rd && op_q == OP_REMOVE) || (cmd.modify && op_q == OP_GET);
    st_raddr = cmd.rd ? last : hs_rdata;
    st_we    = cmd.modify && ok && (op_q == OP_ADD || op_q == OP_REMOVE);
    st_waddr = (op_q == OP_ADD) ? size_idx : hs_rdata;
    st_wdata = (op_q == OP_ADD) ? v_q : st_rdata;
  end

  // handle to slot map
  always_comb begin
    hs_we    = cmd.modify && ok && (op_q == OP_ADD || op_q == OP_REMOVE);
    hs_waddr = (op_q == OP_ADD) ? nh : sh_rdata;
    hs_wdata = (op_q == OP_ADD) ? size_idx : hs_rdata;
  end

  // slot to handle map; last slot takes the freed handle after the hole fix
  always_comb begin
    sh_raddr = (op_q == OP_ADD) ? size_idx : last;
    sh_we    = ok && ((cmd.modify && (op_q == OP_ADD || op_q == OP_REMOVE)) ||
                      (cmd.fin && op_q == OP_REMOVE));
    if (cmd.fin) begin
      sh_waddr = last;
      sh_wdata = h_q;
    end else if (op_q == OP_ADD) begin
      sh_waddr = size_idx;
      sh_wdata = nh;
    end else begin
      sh_waddr = hs_rdata;
      sh_wdata = sh_rdata;
    end
  end

  smds_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  smds_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_h2s (
    .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
    .re(cmd.rd), .raddr(h_q), .rdata(hs_rdata)
  );

  smds_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_s2h (
    .clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
    .re(cmd.rd), .raddr(sh_raddr), .rdata(sh_rdata)
  );

  always_comb begin
    size_next = size;
    free_next = free_cnt;
    case (op_q)
      OP_ADD: begin
        if (ok) begin
          size_next = size + CNT_W'(1);
          if (free_cnt != '0) free_next = free_cnt - CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (ok) begin
          size_next = size_m1;
          free_next = free_cnt + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        size_next = '0;
        free_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size     <= '0;
      free_cnt <= '0;
    end else if (cmd.load) begin
      size     <= size_next;
      free_cnt <= free_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q <= op;
      h_q  <= handle_in;
      v_q  <= value_in;
    end
    if (cmd.load) begin
      handle_out <= (op_q == OP_ADD && ok) ? nh : '0;
      value_out  <= (op_q == OP_GET && ok) ? st_rdata : '0;
      live_count <= size_next;
      status     <= st_c;
    end
  end

endmodule

// File: sv/slot_map_dense_store_top.sv
// slot map with stable handles over a packed store: top level
// an accepted beat steps through the read, modify and fix last slot states into the output register
// one beat at a time: a new beat is taken only once the last one is in its fix state and the
// output register is free, as the map reads and writes of remove go through the registered-read rams
// reset: counts cleared so the store is empty; ram contents are left as they are
module slot_map_dense_store_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  smds_pkg::op_t                   op,
  input  logic [smds_pkg::IDX_W-1:0]      handle_in,
  input  logic [smds_pkg::DATA_WIDTH-1:0] value_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [smds_pkg::IDX_W-1:0]      handle_out,
  output logic [smds_pkg::DATA_WIDTH-1:0] value_out,
  output logic [smds_pkg::CNT_W-1:0]      live_count,
  output smds_pkg::status_t               status
);
  import smds_pkg::*;

  cmd_t cmd;

  smds_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd)
  );

  smds_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .op(op), .handle_in(handle_in), .value_in(value_in),
    .handle_out(handle_out), .value_out(value_out),
    .live_count(live_count), .status(status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("beat accepted while previous one still in flight");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (live_count <= CNT_W'(CAPACITY)))
    else $error("live count beyond capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (live_count == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_handle_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && handle_out != '0) |-> (status == ST_OK))
    else $error("handle returned on a failed beat");

endmodule

// File: bench/tb_slot_map_dense_store_top.sv
// testbench for the slot map block: queued stimulus, mirrored map state, in-order result checks
`timescale 1ns / 1ps

module tb_slot_map_dense_store_top;
  import smds_pkg::*;

  localparam int NUM_BEATS   = 1900;
  localparam int TAIL_BEATS  = 150;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    op_t                   op;
    logic [IDX_W-1:0]      handle;
    logic [DATA_WIDTH-1:0] value;
    logic                  hold;   // wait for every result before this beat goes out
  } slot_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]      handle;
    logic [DATA_WIDTH-1:0] value;
    logic [CNT_W-1:0]      count;
    status_t               status;
  } slot_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  op_t                   op = OP_ADD;
  logic [IDX_W-1:0]      handle_in = '0;
  logic [DATA_WIDTH-1:0] value_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [IDX_W-1:0]      handle_out;
  logic [DATA_WIDTH-1:0] value_out;
  logic [CNT_W-1:0]      live_count;
  status_t               status;

  slot_map_dense_store_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .handle_in  (handle_in),
    .value_in   (value_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .handle_out (handle_out),
    .value_out  (value_out),
    .live_count (live_count),
    .status     (status)
  );

  initial forever #2 clk = ~clk;

  // mirror of the block state, advanced once per accepted beat
  logic [DATA_WIDTH-1:0] mir_words     [CAPACITY];
  logic [IDX_W-1:0]      mir_slot_of   [CAPACITY];
  logic [IDX_W-1:0]      mir_handle_at [CAPACITY];
  logic [CNT_W-1:0]      mir_size = '0;
  logic [CNT_W-1:0]      mir_free = '0;

  slot_req_t    op_queue [$];
  slot_result_t due_results [$];

  // generator view: counts are exact, the handle lists only while in step
  int         gen_size = 0;
  int         gen_free = 0;
  logic [7:0] gen_live [$];
  logic [7:0] gen_freed [$];
  bit         gen_synced = 1'b1;

  int        beats_in = 0;
  int        beats_out = 0;
  int        mismatches = 0;
  int        n_full = 0;
  int        n_range = 0;
  int        peak_live = 0;
  bit        tail_quiet = 1'b0;
  int        tx_gap = 0;
  int        tx_calm = 0;
  int        rx_burst = 0;
  int        rx_calm = 0;
  int        rx_hold = 0;
  bit        rx_hold_done = 1'b0;
  int        idle_cycles = 0;
  slot_req_t    next_req;
  slot_result_t want;

  function automatic slot_result_t apply_slot_op(op_t o, logic [IDX_W-1:0] h,
                                                 logic [DATA_WIDTH-1:0] v);
    slot_result_t     r;
    int               minted;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] nh;
    logic [IDX_W-1:0] hole;
    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] last_h;
    r = '0;
    r.status = ST_OK;
    minted = int'(mir_size) + int'(mir_free);
    case (o)
      OP_ADD: begin
        if (int'(mir_size) >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          slot = mir_size[IDX_W-1:0];
          mir_words[slot] = v;
          // reuse the top of the free stack, which sits at the packed end
          if (mir_free != 0) begin
            nh = mir_handle_at[slot];
            mir_free = mir_free - CNT_W'(1);
          end else begin
            nh = slot;
          end
          mir_slot_of[nh] = slot;
          mir_handle_at[slot] = nh;
          mir_size = mir_size + CNT_W'(1);
          r.handle = nh;
        end
      end
      OP_REMOVE: begin
        if (int'(h) >= minted || mir_size == 0) begin
          r.status = ST_RANGE;
        end else begin
          hole = mir_slot_of[h];
          last = mir_size[IDX_W-1:0] - IDX_W'(1);
          mir_words[hole] = mir_words[last];
          mir_size = mir_size - CNT_W'(1);
          last_h = mir_handle_at[last];
          mir_slot_of[last_h] = hole;
          mir_handle_at[hole] = last_h;
          mir_handle_at[last] = h;
          mir_free = mir_free + CNT_W'(1);
        end
      end
      OP_GET: begin
        if (int'(h) >= minted) r.status = ST_RANGE;
        else r.value = mir_words[mir_slot_of[h]];
      end
      default: begin
        mir_size = '0;
        mir_free = '0;
      end
    endcase
    r.count = mir_size;
    return r;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_live();
    return gen_live[$urandom_range(0, gen_live.size() - 1)];
  endfunction

  function automatic logic [7:0] any_handle();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] minted_handle();
    return 8'($urandom_range(0, gen_size + gen_free - 1));
  endfunction

  task automatic push_req(op_t o, logic [7:0] h, logic [DATA_WIDTH-1:0] v, bit hold);
    int minted;
    int idx;
    slot_req_t q;
    minted = gen_size + gen_free;
    idx = -1;
    case (o)
      OP_ADD: begin
        if (gen_size < CAPACITY) begin
          if (gen_free > 0) begin
            gen_free--;
            if (gen_synced) gen_live.push_back(gen_freed.pop_back());
          end else if (gen_synced) begin
            gen_live.push_back(8'(minted));
          end
          gen_size++;
        end
      end
      OP_REMOVE: begin
        if (int'(h) < minted && gen_size > 0) begin
          gen_size--;
          gen_free++;
          if (gen_synced) begin
            foreach (gen_live[i]) if (gen_live[i] == h && idx < 0) idx = i;
            if (idx < 0) begin
              gen_synced = 1'b0;
            end else begin
              gen_live.delete(idx);
              gen_freed.push_back(h);
            end
          end
        end
      end
      OP_CLEAR: begin
        gen_size = 0;
        gen_free = 0;
        gen_live.delete();
        gen_freed.delete();
        gen_synced = 1'b1;
      end
      default: ;
    endcase
    q.op = o;
    q.handle = h;
    q.value = v;
    q.hold = hold;
    op_queue.push_back(q);
  endtask

  // stimulus
  initial begin
    int  k;
    int  n;
    int  r;
    logic [7:0] h;
    bit  fill_done;
    fill_done = 1'b0;

    push_req(OP_REMOVE, 8'd0, 32'hdead_beef, 1'b0);   // remove on an empty store
    push_req(OP_GET, 8'd0, '0, 1'b0);                 // handle never minted
    push_req(OP_ADD, 8'd0, 32'h0000_0000, 1'b0);
    push_req(OP_ADD, 8'd255, 32'hffff_ffff, 1'b0);
    push_req(OP_ADD, 8'd0, 32'ha5a5_a5a5, 1'b0);
    push_req(OP_GET, 8'd0, '0, 1'b0);
    push_req(OP_GET, 8'd1, '0, 1'b0);
    push_req(OP_GET, 8'd2, '0, 1'b0);
    push_req(OP_GET, 8'd255, '1, 1'b0);
    push_req(OP_REMOVE, 8'd255, '0, 1'b0);
    push_req(OP_REMOVE, 8'd0, '0, 1'b0);              // last element fills the hole
    push_req(OP_GET, 8'd0, '0, 1'b0);                 // freed handle, stale slot
    push_req(OP_GET, 8'd2, '0, 1'b0);
    push_req(OP_ADD, 8'd3, 32'h1234_5678, 1'b0);      // takes handle 0 back
    push_req(OP_REMOVE, 8'd1, '0, 1'b0);
    push_req(OP_REMOVE, 8'd2, '0, 1'b0);
    push_req(OP_ADD, 8'd0, 32'h8000_0001, 1'b0);      // most recently freed first
    push_req(OP_ADD, 8'd0, 32'h7fff_fffe, 1'b0);
    push_req(OP_REMOVE, 8'd0, '0, 1'b0);
    push_req(OP_REMOVE, 8'd0, '0, 1'b0);              // double free
    push_req(OP_GET, 8'd0, '0, 1'b0);
    push_req(OP_ADD, 8'd0, 32'h0f0f_0f0f, 1'b0);
    push_req(OP_CLEAR, 8'd170, 32'h5555_5555, 1'b0);
    push_req(OP_GET, 8'd0, '0, 1'b0);
    push_req(OP_ADD, 8'd85, 32'haaaa_aaaa, 1'b1);

    while (op_queue.size() < NUM_BEATS) begin
      if (!fill_done && op_queue.size() > 600) begin
        // fill to capacity from empty so every handle up to the top gets minted
        fill_done = 1'b1;
        push_req(OP_CLEAR, '0, '0, 1'b0);
        while (gen_size < CAPACITY) push_req(OP_ADD, any_handle(), pick_word(), 1'b0);
        push_req(OP_ADD, 8'd0, pick_word(), 1'b0);
        push_req(OP_ADD, 8'd255, pick_word(), 1'b0);
        push_req(OP_GET, 8'd255, '0, 1'b0);
        push_req(OP_GET, 8'd128, '0, 1'b0);
        while (gen_live.size() > 0) begin
          if ($urandom_range(0, 99) < 75) push_req(OP_REMOVE, pick_live(), $urandom, 1'b0);
          else push_req(OP_GET, pick_live(), $urandom, 1'b0);
        end
        push_req(OP_REMOVE, 8'd255, '0, 1'b0);      // empty but handles outstanding
        push_req(OP_GET, 8'd255, '0, 1'b1);
        push_req(OP_ADD, 8'd0, pick_word(), 1'b0);
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(8, 24);
        for (k = 0; k < n; k++) begin
          r = $urandom_range(0, 99);
          if (gen_live.size() == 0 || (r < 45 && gen_size < CAPACITY))
            push_req(OP_ADD, any_handle(), pick_word(), 1'b0);
          else if (r < 72)
            push_req(OP_REMOVE, pick_live(), $urandom, 1'b0);
          else if (r < 96)
            push_req(OP_GET, pick_live(), $urandom, 1'b0);
          else
            push_req(OP_GET, any_handle(), $urandom, 1'b0);
        end
      end else if (r < 85) begin
        n = $urandom_range(4, 10);
        for (k = 0; k < n; k++) begin
          r = $urandom_range(0, 15);
          if (r == 0) push_req(OP_CLEAR, any_handle(), $urandom, 1'b0);
          else push_req(op_t'(r % 3), any_handle(), $urandom, 1'b0);
        end
        if (!gen_synced) push_req(OP_CLEAR, any_handle(), $urandom, 1'b0);
      end else if (r < 95 && gen_live.size() > 0) begin
        h = pick_live();
        push_req(OP_REMOVE, h, $urandom, 1'b0);
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 1) == 0) push_req(OP_ADD, any_handle(), pick_word(), 1'b0);
          else push_req(OP_GET, minted_handle(), $urandom, 1'b0);
        end
        push_req(OP_REMOVE, h, $urandom, 1'b0);
        push_req(OP_GET, h, $urandom, 1'b0);
        push_req(OP_ADD, any_handle(), pick_word(), 1'b0);
        push_req(OP_GET, minted_handle(), $urandom, 1'b0);
        if (!gen_synced) push_req(OP_CLEAR, any_handle(), $urandom, 1'b0);
      end else begin
        push_req(OP_CLEAR, any_handle(), $urandom, 1'b0);
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) push_req(OP_ADD, any_handle(), pick_word(), 1'b0);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (due_results.size() != 0) mismatches++;

    $display("covered %0d beats and %0d results, live count peaked at %0d of %0d",
             beats_in, beats_out, peak_live, CAPACITY);
    $display("full-store adds %0d, out-of-range handles %0d, mismatches %0d",
             n_full, n_range, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
      tx_calm = 0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_slot_op(op, handle_in, value_in));
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        tail_quiet <= (op_queue.size() < TAIL_BEATS);
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (op_queue.size() == 0 || (op_queue[0].hold && due_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (!tail_quiet && tx_calm == 0 && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else begin
          if (tx_calm > 0) tx_calm--;
          else if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(30, 120);
          next_req = op_queue.pop_front();
          in_valid <= 1'b1;
          op <= next_req.op;
          handle_in <= next_req.handle;
          value_in <= next_req.value;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: handle %0h value %0h count %0d status %0d",
                     handle_out, value_out, live_count, status);
        end else begin
          want = due_results.pop_front();
          if (handle_out !== want.handle || value_out !== want.value ||
              live_count !== want.count || status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: want h=%0h v=%0h n=%0d st=%0d, got h=%0h v=%0h n=%0d st=%0d",
                       beats_out, want.handle, want.value, want.count, want.status,
                       handle_out, value_out, live_count, status);
          end
          if (int'(want.count) > peak_live) peak_live = int'(want.count);
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_RANGE) n_range++;
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!rx_hold_done && beats_in >= 400) begin
        rx_hold_done = 1'b1;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_burst > 0) begin
        rx_burst--;
        out_stall <= 1'b1;
      end else if (rx_calm > 0) begin
        rx_calm--;
        out_stall <= 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
        rx_burst = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(40, 120);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: slot_map_dense_store_top.f
sv/smds_pkg.sv
sv/smds_ram.sv
sv/smds_ctrl.sv
sv/smds_dp.sv
sv/slot_map_dense_store_top.sv
bench/tb_slot_map_dense_store_top.sv
